### sv/iqed_pkg.sv
package iqed_pkg;

  // Field and state widths.
  localparam int unsigned IN_W  = 16;
  localparam int unsigned WIN_W = 10;
  localparam int unsigned ENV_W = 26;
  localparam int unsigned SUM_W = 27;

  // Defaults for the top-level parameters.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MAX_WINDOW_DEF   = 1023;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(480);

  // Magnitude datapath. The envelope is floor(isqrt(16 * power) / 5), which is
  // the same as the root of floor(16 * power / 25).
  localparam int unsigned SQ_W     = 2 * SUM_W;
  localparam int unsigned PWR_W    = SQ_W + 1;
  localparam int unsigned SCALE_SH = 4;
  localparam int unsigned ROOT_W   = (PWR_W + 1) / 2;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned ALU_W    = ROOT_W + 3;
  localparam int unsigned STEP_W   = $clog2(ROOT_W + 1);
  localparam int unsigned MUL_W    = ROOT_W;

  // floor(x / 5) equals (x * RECIP5) >> RECIP_SH for every x below 2^30.
  localparam int unsigned      RECIP_SH = 30;
  localparam logic [MUL_W-1:0] RECIP5   = MUL_W'(214748365);

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] i_sum;
    logic signed [SUM_W-1:0] q_sum;
  } iqed_close_t;

endpackage

### sv/iqed_accum.sv
module iqed_accum #(
  parameter int unsigned SAMPLE_WIDTH = iqed_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_WINDOW   = iqed_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iqed_pkg::WIN_W-1:0]    cfg_data_i,
  input  logic                          smp_we_i,
  input  logic [iqed_pkg::IN_W-1:0]     smp_data_i,
  output iqed_pkg::iqed_close_t         close_o
);

  localparam int unsigned WinW      = iqed_pkg::WIN_W;
  localparam int unsigned SumW      = iqed_pkg::SUM_W;
  localparam int unsigned WinMax    = (1 << WinW) - 1;
  localparam int unsigned MaxLenInt = (MAX_WINDOW > WinMax) ? WinMax : MAX_WINDOW;
  localparam logic [WinW-1:0] MaxLen = WinW'(MaxLenInt);

  logic [WinW-1:0]        win_q;
  logic [1:0]             phase_q;
  logic [WinW-1:0]        count_q;
  logic signed [SumW-1:0] i_sum_q, i_sum_d;
  logic signed [SumW-1:0] q_sum_q, q_sum_d;

  logic [WinW-1:0]        len;
  logic [WinW:0]          count_inc;
  logic signed [SumW-1:0] sample;
  logic signed [SumW-1:0] operand;
  logic signed [SumW-1:0] result;
  logic                   last;

  assign sample = {{(SumW - SAMPLE_WIDTH){smp_data_i[SAMPLE_WIDTH-1]}},
                   smp_data_i[SAMPLE_WIDTH-1:0]};

  always_comb begin
    len = win_q;
    if (len == '0) begin
      len = WinW'(1);
    end
    if (len > MaxLen) begin
      len = MaxLen;
    end
  end

  // Even phases feed the in-phase sum, odd ones the quadrature sum; the
  // upper phase bit selects subtraction.
  assign operand   = phase_q[0] ? q_sum_q : i_sum_q;
  assign result    = phase_q[1] ? (operand - sample) : (operand + sample);
  assign count_inc = {1'b0, count_q} + (WinW + 1)'(1);
  assign last      = count_inc >= {1'b0, len};

  always_comb begin
    i_sum_d = i_sum_q;
    q_sum_d = q_sum_q;
    if (phase_q[0]) begin
      q_sum_d = result;
    end else begin
      i_sum_d = result;
    end
  end

  assign close_o.start = smp_we_i && last;
  assign close_o.i_sum = i_sum_d;
  assign close_o.q_sum = q_sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= iqed_pkg::WIN_RESET;
      phase_q <= '0;
      count_q <= '0;
      i_sum_q <= '0;
      q_sum_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_data_i;
      end
      if (smp_we_i) begin
        if (last) begin
          phase_q <= '0;
          count_q <= '0;
          i_sum_q <= '0;
          q_sum_q <= '0;
        end else begin
          phase_q <= phase_q + 2'd1;
          count_q <= count_inc[WinW-1:0];
          i_sum_q <= i_sum_d;
          q_sum_q <= q_sum_d;
        end
      end
    end
  end

endmodule

### sv/iqed_mag.sv
module iqed_mag (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iqed_pkg::iqed_close_t         close_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output logic [iqed_pkg::ENV_W-1:0]    res_o
);

  localparam int unsigned SumW    = iqed_pkg::SUM_W;
  localparam int unsigned SqW     = iqed_pkg::SQ_W;
  localparam int unsigned PwrW    = iqed_pkg::PWR_W;
  localparam int unsigned RadW    = iqed_pkg::RAD_W;
  localparam int unsigned RootW   = iqed_pkg::ROOT_W;
  localparam int unsigned AluW    = iqed_pkg::ALU_W;
  localparam int unsigned StepW   = iqed_pkg::STEP_W;
  localparam int unsigned EnvW    = iqed_pkg::ENV_W;
  localparam int unsigned MulW    = iqed_pkg::MUL_W;
  localparam int unsigned ScaleW  = iqed_pkg::SCALE_SH;
  localparam int unsigned RecipSh = iqed_pkg::RECIP_SH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ_I = 3'd1;
  localparam logic [2:0] ST_SQ_Q = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [StepW-1:0] RootLast = StepW'(RootW - 1);

  logic [2:0]          state_q, state_d;
  logic [SumW-1:0]     mag_i_q, mag_q_q;
  logic [SqW-1:0]      prod_q;
  logic [SqW-1:0]      pwr_i_q;
  logic [RadW-1:0]     rad_q;
  logic [AluW-1:0]     rem_q;
  logic [RootW-1:0]    root_q;
  logic [EnvW-1:0]     env_q;
  logic [StepW-1:0]    step_q;

  logic [MulW-1:0]     mul_a, mul_b;
  logic [2*MulW-1:0]   mul_res;
  logic [PwrW-1:0]     pwr_sum;
  logic [PwrW+ScaleW-1:0] scaled;
  logic [AluW-1:0]     alu_a, alu_b;
  logic [AluW:0]       alu_diff;
  logic                alu_ge;

  function automatic logic [SumW-1:0] abs_val(input logic signed [SumW-1:0] v);
    abs_val = v[SumW-1] ? (~v + SumW'(1)) : v;
  endfunction

  // One multiplier serves both squares and the division of the root by five.
  always_comb begin
    case (state_q)
      ST_SQ_I: begin
        mul_a = MulW'(mag_i_q);
        mul_b = MulW'(mag_i_q);
      end
      ST_SQ_Q: begin
        mul_a = MulW'(mag_q_q);
        mul_b = MulW'(mag_q_q);
      end
      default: begin
        mul_a = MulW'(root_q);
        mul_b = iqed_pkg::RECIP5;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;
  assign pwr_sum = {1'b0, pwr_i_q} + {1'b0, prod_q};

  // A window is at most 1023 samples, so both sums stay within 2^24 and the
  // scaled power always fits the radicand.
  assign scaled  = {pwr_sum, ScaleW'(0)};

  // Shared shift, compare and subtract for the bit-pair square root.
  assign alu_a    = {rem_q[AluW-3:0], rad_q[RadW-1 -: 2]};
  assign alu_b    = {1'b0, root_q, 2'b01};
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[AluW];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (close_i.start) begin
          state_d = ST_SQ_I;
        end
      end
      ST_SQ_I: state_d = ST_SQ_Q;
      ST_SQ_Q: state_d = ST_ADD;
      ST_ADD:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (step_q == RootLast) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:  state_d = ST_DONE;
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ADD) begin
        step_q <= '0;
      end else if (state_q == ST_ROOT) begin
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mag_i_q <= abs_val(close_i.i_sum);
        mag_q_q <= abs_val(close_i.q_sum);
      end
      ST_SQ_I: begin
        prod_q <= mul_res[SqW-1:0];
      end
      ST_SQ_Q: begin
        pwr_i_q <= prod_q;
        prod_q  <= mul_res[SqW-1:0];
      end
      ST_ADD: begin
        rad_q  <= scaled[RadW-1:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        rem_q  <= alu_ge ? alu_diff[AluW-1:0] : alu_a;
        root_q <= {root_q[RootW-2:0], alu_ge};
      end
      ST_DIV: begin
        env_q <= mul_res[RecipSh +: EnvW];
      end
      default: begin
      end
    endcase
  end

  assign busy_o      = state_q != ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign res_o       = env_q;

endmodule

### sv/iq_envelope_detector_unit.sv
// Channel   Direction  Handshake                  Word
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i, window length
// sample    in         in_valid_i / in_stall_o    adc_sample_i
// envelope  out        out_valid_o / out_stall_i  envelope_o
//
// A sample that does not close a window is taken whenever the magnitude
// unit is idle, so such samples may arrive back to back. A sample that
// closes a window starts the magnitude unit, and the sample input stalls
// while it runs: the squares on the shared multiplier, their sum, 28
// square-root steps on the shared subtractor, the division of the root by
// five on the multiplier and the hand-over of the word to the output.
// Reset clears sums, count, phase and output valid and loads a length of 480.
// A full output register holding a word does not stall the input; the unit
// only waits for it when it has a new word to hand over.
module iq_envelope_detector_unit #(
  parameter int unsigned SAMPLE_WIDTH = iqed_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_WINDOW   = iqed_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [iqed_pkg::WIN_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [iqed_pkg::IN_W-1:0]     adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [iqed_pkg::ENV_W-1:0]    envelope_o
);

  iqed_pkg::iqed_close_t           close;
  logic                            busy;
  logic                            res_valid;
  logic                            res_take;
  logic [iqed_pkg::ENV_W-1:0]      res;
  logic                            smp_we;
  logic                            out_valid_q;
  logic [iqed_pkg::ENV_W-1:0]      envelope_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign smp_we      = in_valid_i && !busy;

  iqed_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .smp_we_i   (smp_we),
    .smp_data_i (adc_sample_i),
    .close_o    (close)
  );

  iqed_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .close_i     (close),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // The output register takes a new word when it is empty or being drained.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      envelope_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign envelope_o  = envelope_q;

endmodule

### verif/tb_top.sv
module tb_top;

  localparam int unsigned InW  = iqed_pkg::IN_W;
  localparam int unsigned WinW = iqed_pkg::WIN_W;
  localparam int unsigned EnvW = iqed_pkg::ENV_W;
  localparam int unsigned SumW = iqed_pkg::SUM_W;
  localparam int unsigned SmpW = iqed_pkg::SAMPLE_WIDTH_DEF;

  // Comfortably longer than a magnitude pass of the block.
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  localparam logic [InW-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [InW-1:0] SAMPLE_MAX = 16'h7FFF;

  typedef enum logic [1:0] {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;
  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {PH_COS_POS, PH_SIN_POS, PH_COS_NEG, PH_SIN_NEG} carrier_ph_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [InW-1:0]  value;
    logic            typed;
    logic [EnvW-1:0] envelope;
  } drill_row_t;

  typedef struct packed {
    pace_e           pace;
    logic [WinW-1:0] window;
    int unsigned     items;
    logic            loud;
    logic            hold;
  } stage_t;

  // With a window of one sample the envelope reduces to floor(4 * |x| / 5).
  localparam drill_row_t DRILL [26] = '{
    '{ROW_CFG,    16'd1,    1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 26'd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 26'd26213},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 26'd26214},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 26'd0},
    '{ROW_SAMPLE, 16'h0005, 1'b1, 26'd4},
    '{ROW_CFG,    16'd0,    1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 26'd26214},
    '{ROW_SAMPLE, 16'h0001, 1'b1, 26'd0},
    '{ROW_CFG,    16'd4,    1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h0064, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'hFF9C, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 26'd160},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 26'd0},
    '{ROW_CFG,    16'd8,    1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h0003, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h0004, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'hEDCB, 1'b0, 26'd0},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 26'd0},
    // Five samples are already in, so the next one closes the shorter window.
    '{ROW_CFG,    16'd3,    1'b0, 26'd0},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 26'd0}
  };

  localparam stage_t STAGES [9] = '{
    '{PACE_FULL,       10'd1,    30,   1'b0, 1'b0},
    '{PACE_SEND_IDLE,  10'd5,    30,   1'b0, 1'b0},
    '{PACE_RECV_STALL, 10'd0,    25,   1'b0, 1'b0},
    '{PACE_BOTH,       10'd16,   32,   1'b0, 1'b0},
    '{PACE_FULL,       10'd1023, 1023, 1'b1, 1'b0},
    '{PACE_SEND_IDLE,  10'd3,    30,   1'b0, 1'b1},
    '{PACE_RECV_STALL, 10'd7,    30,   1'b0, 1'b0},
    '{PACE_BOTH,       10'd2,    20,   1'b0, 1'b0},
    '{PACE_BOTH,       10'd11,   30,   1'b0, 1'b0}
  };

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            cfg_valid_i  = 1'b0;
  logic [WinW-1:0] cfg_data_i   = '0;
  logic            in_valid_i   = 1'b0;
  logic [InW-1:0]  adc_sample_i = '0;
  logic            out_stall_i  = 1'b0;
  logic            cfg_ready_o;
  logic            in_stall_o;
  logic            out_valid_o;
  logic [EnvW-1:0] envelope_o;

  // Mirror of the block's state.
  logic [WinW-1:0]        window_len;
  carrier_ph_e            carrier_ph;
  int unsigned            taken;
  logic signed [SumW-1:0] i_acc;
  logic signed [SumW-1:0] q_acc;

  logic [EnvW-1:0] envelope_q [$];
  logic [EnvW-1:0] oldest_env;
  int unsigned     mismatches    = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct     = 0;
  int unsigned     cycle_count   = 0;

  iq_envelope_detector_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .envelope_o   (envelope_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mixes one sample into the sums; returns 1 when it closes the window.
  function automatic bit mix_sample(input logic [InW-1:0] raw,
                                    output logic [EnvW-1:0] env);
    logic signed [SmpW-1:0] x;
    int unsigned     len;
    longint unsigned ai, aq, power, root, probe;
    x   = raw[SmpW-1:0];
    len = (window_len == '0) ? 1 : window_len;
    env = '0;
    case (carrier_ph)
      PH_COS_POS: i_acc += x;
      PH_SIN_POS: q_acc += x;
      PH_COS_NEG: i_acc -= x;
      default:    q_acc -= x;
    endcase
    carrier_ph = carrier_ph_e'(carrier_ph + 2'd1);
    taken++;
    if (taken < len) return 1'b0;
    ai    = (i_acc < 0) ? -longint'(i_acc) : longint'(i_acc);
    aq    = (q_acc < 0) ? -longint'(q_acc) : longint'(q_acc);
    power = ((ai * ai + aq * aq) * 16) / 25;
    // Bitwise integer square root, two bits of the radicand per step.
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > power) probe >>= 2;
    while (probe != 0) begin
      if (power >= root + probe) begin
        power -= root + probe;
        root   = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    env        = root[EnvW-1:0];
    i_acc      = '0;
    q_acc      = '0;
    carrier_ph = PH_COS_POS;
    taken      = 0;
    return 1'b1;
  endfunction

  // Drops the sample valid and waits until the block has nothing in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (envelope_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WinW-1:0] len);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_len = len;
  endtask

  // Valid is left high on return, so a following word may go back to back.
  task automatic send_sample(input logic [InW-1:0] raw, input logic typed,
                             input logic [EnvW-1:0] typed_env);
    logic [EnvW-1:0] env;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    if (mix_sample(raw, env)) envelope_q.push_back(typed ? typed_env : env);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (envelope_q.size() == 0) begin
        $display("%0t: envelope word %0d arrived with none expected", $time, envelope_o);
        mismatches++;
      end else begin
        oldest_env = envelope_q.pop_front();
        if (envelope_o !== oldest_env) begin
          $display("%0t: envelope expected %0d, got %0d", $time, oldest_env, envelope_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("iq_envelope_detector_unit test failed");
    $finish;
  end

  initial begin
    logic [InW-1:0] raw;
    window_len = iqed_pkg::WIN_RESET;
    carrier_ph = PH_COS_POS;
    taken      = 0;
    i_acc      = '0;
    q_acc      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DRILL[r]) begin
      if (DRILL[r].kind == ROW_CFG) write_window(DRILL[r].value[WinW-1:0]);
      else send_sample(DRILL[r].value, DRILL[r].typed, DRILL[r].envelope);
    end

    foreach (STAGES[s]) begin
      write_window(STAGES[s].window);
      case (STAGES[s].pace)
        PACE_FULL:       begin send_idle_pct = 0;  stall_pct = 0;  end
        PACE_SEND_IDLE:  begin send_idle_pct = 79; stall_pct = 0;  end
        PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 79; end
        default:         begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      for (int unsigned n = 0; n < STAGES[s].items; n++) begin
        if (STAGES[s].hold && n == STAGES[s].items / 2) begin
          // Hold the input back until every envelope word is out.
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (envelope_q.size() != 0);
        end
        if (STAGES[s].loud && $urandom_range(7) != 0) begin
          // Push both sums towards their largest magnitude.
          raw = (carrier_ph inside {PH_COS_POS, PH_SIN_POS}) ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
          case ($urandom_range(7))
            0:       raw = SAMPLE_MIN;
            1:       raw = SAMPLE_MAX;
            2:       raw = InW'($urandom_range(32)) - InW'(16);
            default: raw = InW'($urandom);
          endcase
        end
        send_sample(raw, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && envelope_q.size() == 0) begin
      $display("iq_envelope_detector_unit test passed");
    end else begin
      $display("iq_envelope_detector_unit test failed");
    end
    $finish;
  end

endmodule

### files.f
sv/iqed_pkg.sv
sv/iqed_accum.sv
sv/iqed_mag.sv
sv/iq_envelope_detector_unit.sv
verif/tb_top.sv
